>>> src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg: shared definitions for the dense layer with ReLU
// Sizes, field widths, item kinds, register indexes and internal types.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int MAX_INPUTS  = 1024;
    localparam int MAX_NEURONS = 16;
    localparam int DATA_WIDTH  = 16;

    localparam int AI_W = (MAX_INPUTS  > 1) ? $clog2(MAX_INPUTS)  : 1;
    localparam int NB_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int CI_W = AI_W + 1;
    localparam int CN_W = NB_W + 1;
    localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
    localparam int WA_W   = $clog2(WDEPTH);

    localparam int FRAC_BITS = 8;
    localparam int ACC_W     = 2 * DATA_WIDTH + AI_W + 1;
    localparam int ACT_W     = DATA_WIDTH - 1;
    localparam int ACT_MAX   = (1 << (DATA_WIDTH - 1)) - 1;

    localparam int KIND_W       = 2;
    localparam int NEURON_IDX_W = 4;
    localparam int INPUT_IDX_W  = 10;
    localparam int VALUE_W      = 16;
    localparam int OUT_NEURON_W = 4;
    localparam int ACT_FIELD_W  = 15;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 24;

    localparam int CFG_IC_W    = 11;
    localparam int CFG_NC_W    = 5;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int IC_RESET    = 784;
    localparam int NC_RESET    = 12;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT     = 2'd0,
        KIND_BIAS       = 2'd1,
        KIND_ACTIVATION = 2'd2,
        KIND_COMPUTE    = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INPUT_COUNT  = 2'd0,
        CFG_NEURON_COUNT = 2'd1,
        CFG_RSVD_2       = 2'd2,
        CFG_RSVD_3       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_bias;
        logic in_valid;
    } mac_ctrl_t;

    typedef struct packed {
        logic p_valid;
    } mac_stat_t;

endpackage

>>> src/dlr_ram.sv
// ----------------------------------------------------------------------------
// dlr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dlr_mac.sv
// ----------------------------------------------------------------------------
// dlr_mac: shared multiply-accumulate unit
// Registered signed product, then a wide accumulator preloaded with the bias.
// ----------------------------------------------------------------------------
module dlr_mac
    import dlr_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mac_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0] bias,
    input  logic signed [DATA_WIDTH-1:0] weight,
    input  logic signed [DATA_WIDTH-1:0] act,
    output mac_stat_t                    stat,
    output logic signed [ACC_W-1:0]      acc
);

    logic signed [2*DATA_WIDTH-1:0] p_reg;
    logic                           p_valid_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [ACC_W-1:0]        bias_ext;

    always_comb begin
        bias_ext = ACC_W'(bias) <<< FRAC_BITS;
        acc_next = acc_reg;
        if (ctrl.load_bias) begin
            acc_next = bias_ext;
        end else if (p_valid_reg) begin
            acc_next = acc_reg + ACC_W'(p_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= ctrl.in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg   <= weight * act;
        acc_reg <= acc_next;
    end

    assign stat.p_valid = p_valid_reg;
    assign acc          = acc_reg;

endmodule

>>> src/dense_layer_relu.sv
// ----------------------------------------------------------------------------
// dense_layer_relu: fully connected layer with ReLU in Q8.8
// Stores weights, biases and activations, then computes every neuron on one
// shared multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one item per transfer. s_tuser holds the
// kind; weight, bias and activation writes produce no result. A compute
// item walks neurons 0 to neuron_count-1 and sends one result per neuron on
// the output stream, with m_tlast on the final neuron. Each neuron, with
// input_count capped at 1024, takes a bias read, one weight and activation
// read per input through the shared multiplier and accumulator, a drain of
// the read, product and accumulate pipeline and a hand-over of the result to
// the output register; an empty dot product skips the per-input reads. A
// compute item keeps s_tready low from its transfer until the final result
// is in the output register. Store writes sustain one per cycle while no
// compute item is running. When the receiver stalls, the finished
// result waits in the output register and the sequencer holds until it is
// taken; once the final result of a layer waits there, writes are accepted
// again. Reset sets input_count to 784 and neuron_count to 12; the stores are
// not cleared and must be written before they are used. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dense_layer_relu
    import dlr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: neuron_index[3:0], input_index[9:0], value[15:0].
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [KIND_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: out_neuron[3:0], activation[14:0].
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    state_t                  state_reg, state_next;
    logic [CFG_IC_W-1:0]     ic_reg;
    logic [CFG_NC_W-1:0]     nc_reg;
    logic [AI_W-1:0]         i_cnt_reg, i_cnt_next;
    logic [NB_W-1:0]         n_cnt_reg, n_cnt_next;
    logic                    rd_valid_reg;
    logic                    bias_pend_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                    s_accept;
    kind_t                   kind;
    logic [NEURON_IDX_W-1:0] s_neuron_index;
    logic [INPUT_IDX_W-1:0]  s_input_index;
    logic [VALUE_W-1:0]      s_value;
    logic                    n_in_range;
    logic                    i_in_range;
    logic [CI_W-1:0]         ni;
    logic [CN_W-1:0]         nn;
    logic                    last_neuron;

    logic                    w_we, b_we, a_we;
    logic [WA_W-1:0]         w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0]   w_rdata, b_rdata, a_rdata;

    mac_ctrl_t               mac_ctrl;
    mac_stat_t               mac_stat;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_shift;
    logic [ACT_W-1:0]        res;

    assign kind           = kind_t'(s_tuser);
    assign s_neuron_index = s_tdata[NEURON_IDX_W-1:0];
    assign s_input_index  = s_tdata[NEURON_IDX_W +: INPUT_IDX_W];
    assign s_value        = s_tdata[NEURON_IDX_W+INPUT_IDX_W +: VALUE_W];
    assign s_tready       = (state_reg == ST_IDLE);
    assign s_accept       = s_tvalid && s_tready;

    assign n_in_range = (32'(s_neuron_index) < MAX_NEURONS);
    assign i_in_range = (32'(s_input_index) < MAX_INPUTS);

    assign ni = (32'(ic_reg) > MAX_INPUTS)  ? CI_W'(MAX_INPUTS)  : CI_W'(ic_reg);
    assign nn = (32'(nc_reg) > MAX_NEURONS) ? CN_W'(MAX_NEURONS) : CN_W'(nc_reg);
    assign last_neuron = ((CN_W'(n_cnt_reg) + CN_W'(1)) == nn);

    assign w_we = s_accept && (kind == KIND_WEIGHT) && n_in_range && i_in_range;
    assign b_we = s_accept && (kind == KIND_BIAS) && n_in_range;
    assign a_we = s_accept && (kind == KIND_ACTIVATION) && i_in_range;

    assign w_waddr = WA_W'(s_neuron_index) * WA_W'(MAX_INPUTS) + WA_W'(s_input_index);
    assign w_raddr = WA_W'(n_cnt_reg) * WA_W'(MAX_INPUTS) + WA_W'(i_cnt_reg);

    dlr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WDEPTH)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (DATA_WIDTH'(s_value)),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_NEURONS)) u_bias_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (NB_W'(s_neuron_index)),
        .wdata (DATA_WIDTH'(s_value)),
        .raddr (n_cnt_reg),
        .rdata (b_rdata)
    );

    dlr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_INPUTS)) u_act_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (AI_W'(s_input_index)),
        .wdata (DATA_WIDTH'(s_value)),
        .raddr (i_cnt_reg),
        .rdata (a_rdata)
    );

    assign mac_ctrl.load_bias = bias_pend_reg;
    assign mac_ctrl.in_valid  = rd_valid_reg;

    dlr_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .bias    (b_rdata),
        .weight  (w_rdata),
        .act     (a_rdata),
        .stat    (mac_stat),
        .acc     (acc)
    );

    always_comb begin
        acc_shift = acc >>> FRAC_BITS;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc_shift > ACC_W'(ACT_MAX)) begin
            res = ACT_W'(ACT_MAX);
        end else begin
            res = acc_shift[ACT_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        i_cnt_next    = i_cnt_reg;
        n_cnt_next    = n_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (kind == KIND_COMPUTE) && (nn != '0)) begin
                    n_cnt_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                i_cnt_next = '0;
                state_next = (ni == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN: begin
                if (CI_W'(i_cnt_reg) == (ni - CI_W'(1))) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_cnt_next = i_cnt_reg + AI_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !mac_stat.p_valid && !bias_pend_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = last_neuron;
                    m_tdata_next  = M_TDATA_W'({ACT_FIELD_W'(res), OUT_NEURON_W'(n_cnt_reg)});
                    if (last_neuron) begin
                        state_next = ST_IDLE;
                    end else begin
                        n_cnt_next = n_cnt_reg + NB_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ic_reg        <= CFG_IC_W'(IC_RESET);
            nc_reg        <= CFG_NC_W'(NC_RESET);
            i_cnt_reg     <= '0;
            n_cnt_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            bias_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_cnt_reg     <= i_cnt_next;
            n_cnt_reg     <= n_cnt_next;
            rd_valid_reg  <= (state_reg == ST_RUN);
            bias_pend_reg <= (state_reg == ST_LOAD);
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en) begin
                if (cfg_index == CFG_INPUT_COUNT) begin
                    ic_reg <= cfg_data[CFG_IC_W-1:0];
                end else if (cfg_index == CFG_NEURON_COUNT) begin
                    nc_reg <= cfg_data[CFG_NC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    a_emit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (!rd_valid_reg && !mac_stat.p_valid && !bias_pend_reg))
        else $error("Result taken while the accumulator pipeline was still busy.");

    a_bias_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        bias_pend_reg |-> !mac_stat.p_valid)
        else $error("Bias preload collided with a pending product.");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("Sequencer moved on while the output register was full.");

    a_last_neuron: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_next && !m_tvalid_reg && m_tlast_next) |=> (state_reg == ST_IDLE))
        else $error("Final neuron did not return the sequencer to idle.");

endmodule
